@@ rtl/stc_pkg.sv @@
// Shared types, constants and codes for the serial tone command decoder.
package stc_pkg;

   localparam int FRAME_BYTES = 3;
   localparam logic [1:0] LAST_COUNT = 2'(FRAME_BYTES - 1);

   localparam int ID_W    = 7;
   localparam int FREQ_W  = 13;
   localparam int VELO_W  = 7;
   localparam int DIVD_W  = 18;
   localparam int QUO_W   = 8;
   localparam int STEP_W  = 3;
   localparam int DUTY_W  = 10;

   localparam logic [ID_W-1:0] MOTOR_A_ID_RST = 7'd4;
   localparam logic [ID_W-1:0] MOTOR_B_ID_RST = 7'd5;

   localparam logic [DIVD_W-1:0] K_BAND_LO  = 18'd11730;
   localparam logic [DIVD_W-1:0] K_BAND_MID = 18'd47058;
   localparam logic [DIVD_W-1:0] K_BAND_HI  = 18'd190476;

   localparam logic [FREQ_W-1:0] F_MIN     = 13'd48;
   localparam logic [FREQ_W-1:0] F_LO_TOP  = 13'd188;
   localparam logic [FREQ_W-1:0] F_MID_TOP = 13'd750;
   localparam logic [FREQ_W-1:0] F_MAX     = 13'd2000;

   localparam logic [5:0] VELO_MAX  = 6'd60;
   localparam logic [7:0] DUTY_BASE = 8'd255;

   typedef enum logic [1:0] {
      STAT_RUN   = 2'd0,
      STAT_STOP  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PRE_DIV64   = 2'd0,
      PRE_DIV256  = 2'd1,
      PRE_DIV1024 = 2'd2
   } prescale_type;

   typedef enum logic [1:0] {
      REG_MOTOR_A_ID = 2'd0,
      REG_MOTOR_B_ID = 2'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic              done;
      logic              motor;
      logic [FREQ_W-1:0] freq;
      logic [VELO_W-1:0] velo;
   } frame_type;

endpackage

@@ rtl/stc_frame.sv @@
// Byte framer: address match, byte counting and payload capture.
module stc_frame import stc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      rx_byte,
   input  logic [ID_W-1:0] motor_a_id,
   input  logic [ID_W-1:0] motor_b_id,
   output frame_type       frame
);

   logic              cap_ff, cap_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              tgt_ff, tgt_in;
   logic [VELO_W-1:0] pay0_ff, pay0_in;
   logic [VELO_W-1:0] pay1_ff, pay1_in;
   logic              done;

   always_comb begin
      cap_in  = cap_ff;
      cnt_in  = cnt_ff;
      tgt_in  = tgt_ff;
      pay0_in = pay0_ff;
      pay1_in = pay1_ff;
      done    = 1'b0;
      if (accept) begin
         if (rx_byte[7]) begin
            // motor A wins when both ids match
            if (rx_byte[6:0] == motor_a_id) begin
               cap_in = 1'b1;
               tgt_in = 1'b0;
            end else if (rx_byte[6:0] == motor_b_id) begin
               cap_in = 1'b1;
               tgt_in = 1'b1;
            end else begin
               cap_in = 1'b0;
            end
            cnt_in = 2'd0;
         end else if (cap_ff) begin
            if (cnt_ff < LAST_COUNT) begin
               if (cnt_ff[0]) begin
                  pay1_in = rx_byte[6:0];
               end else begin
                  pay0_in = rx_byte[6:0];
               end
               cnt_in = cnt_ff + 2'd1;
            end else begin
               cap_in = 1'b0;
               cnt_in = 2'd0;
               done   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         cnt_ff <= 2'd0;
         tgt_ff <= 1'b0;
      end else begin
         cap_ff <= cap_in;
         cnt_ff <= cnt_in;
         tgt_ff <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      pay0_ff <= pay0_in;
      pay1_ff <= pay1_in;
   end

   // halved 14-bit frequency
   assign frame.done  = done;
   assign frame.motor = tgt_ff;
   assign frame.freq  = {pay0_ff, pay1_ff[6:1]};
   assign frame.velo  = rx_byte[6:0];

endmodule

@@ rtl/stc_div.sv @@
// Restoring divider, one quotient bit per cycle, eight-bit quotient.
module stc_div import stc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [FREQ_W-1:0] divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   localparam int WIDE_W = FREQ_W + QUO_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [FREQ_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [WIDE_W-1:0] shifted;
   logic [WIDE_W-1:0] rem_wide;
   logic              ge;

   // quotient is known to stay below 2^QUO_W, so the divisor starts shifted by QUO_W-1
   assign shifted  = {{QUO_W{1'b0}}, dvs_ff} << step_ff;
   assign rem_wide = {{(WIDE_W-DIVD_W){1'b0}}, rem_ff};
   assign ge       = rem_wide >= shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W - 1);
         rem_in  = dividend;
         dvs_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = DIVD_W'(rem_wide - shifted);
         end
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/serial_tone_command_to_timer_setup.sv @@
// A frame's last byte sends the state machine to ST_DIV for a running tone (8 divide steps)
// and on to ST_HOLD, or straight to ST_HOLD for stop or out of range; ST_HOLD loads the word.
// Throughput: one byte a cycle, except that after a frame's last byte req_ready stays low
// until the shared divider, when used, has finished and the word has moved to the output register.
// Reset: synchronous, active high; capture off, ids back to 4 and 5, output word empty.
module serial_tone_command_to_timer_setup import stc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_motor_sel,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_prescale_code,
   output logic [QUO_W-1:0]  rsp_period_compare,
   output logic [DUTY_W-1:0] rsp_duty_compare,
   output logic [FREQ_W-1:0] rsp_tone_freq,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [ID_W-1:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [ID_W-1:0] id_a_ff, id_a_in;
   logic [ID_W-1:0] id_b_ff, id_b_in;

   frame_type   frame;
   logic             div_start;
   logic             div_done;
   logic [QUO_W-1:0] quotient;
   logic             req_accept;
   logic             slot_free;

   // decode of the completed frame
   status_type        f_status;
   prescale_type      f_pre;
   logic [DIVD_W-1:0] f_k;
   logic [7:0]        v_dbl;
   logic [5:0]        v_clamp;
   logic [DUTY_W-1:0] f_duty;

   // working word
   logic              motor_ff, motor_in;
   status_type        status_ff, status_in;
   prescale_type      pre_ff, pre_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_motor_ff;
   status_type        rsp_status_ff;
   prescale_type      rsp_pre_ff;
   logic [QUO_W-1:0]  rsp_per_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic [FREQ_W-1:0] rsp_freq_ff;
   logic              load_rsp;

   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign slot_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      id_a_in = id_a_ff;
      id_b_in = id_b_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MOTOR_A_ID: id_a_in = csr_wdata;
            REG_MOTOR_B_ID: id_b_in = csr_wdata;
            default: ;
         endcase
      end
   end

   stc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .rx_byte    (req_rx_byte),
      .motor_a_id (id_a_ff),
      .motor_b_id (id_b_ff),
      .frame      (frame)
   );

   always_comb begin
      f_status = STAT_RANGE;
      f_pre    = PRE_DIV64;
      f_k      = K_BAND_HI;
      if (frame.freq == '0) begin
         f_status = STAT_STOP;
      end else if (frame.freq > F_MIN && frame.freq <= F_LO_TOP) begin
         f_status = STAT_RUN;
         f_pre    = PRE_DIV1024;
         f_k      = K_BAND_LO;
      end else if (frame.freq > F_LO_TOP && frame.freq <= F_MID_TOP) begin
         f_status = STAT_RUN;
         f_pre    = PRE_DIV256;
         f_k      = K_BAND_MID;
      end else if (frame.freq > F_MID_TOP && frame.freq <= F_MAX) begin
         f_status = STAT_RUN;
         f_pre    = PRE_DIV64;
         f_k      = K_BAND_HI;
      end
   end

   assign v_dbl   = {frame.velo, 1'b0};
   assign v_clamp = (v_dbl > {2'b00, VELO_MAX}) ? VELO_MAX : v_dbl[5:0];
   assign f_duty  = {DUTY_BASE - {2'b00, v_clamp}, 2'b00};

   stc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (f_k),
      .divisor  (frame.freq),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (frame.done) begin
               state_in = (f_status == STAT_RUN) ? ST_DIV : ST_HOLD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = frame.done && (f_status == STAT_RUN);
         end
         ST_DIV:  ;
         ST_HOLD: load_rsp = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      motor_in  = motor_ff;
      status_in = status_ff;
      pre_in    = pre_ff;
      duty_in   = duty_ff;
      freq_in   = freq_ff;
      if (frame.done) begin
         motor_in  = frame.motor;
         status_in = f_status;
         freq_in   = frame.freq;
         pre_in    = (f_status == STAT_RUN) ? f_pre : PRE_DIV64;
         duty_in   = (f_status == STAT_RUN) ? f_duty : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_a_ff      <= MOTOR_A_ID_RST;
         id_b_ff      <= MOTOR_B_ID_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_a_ff      <= id_a_in;
         id_b_ff      <= id_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      motor_ff  <= motor_in;
      status_ff <= status_in;
      pre_ff    <= pre_in;
      duty_ff   <= duty_in;
      freq_ff   <= freq_in;
      if (load_rsp) begin
         rsp_motor_ff  <= motor_ff;
         rsp_status_ff <= status_ff;
         rsp_pre_ff    <= pre_ff;
         rsp_per_ff    <= (status_ff == STAT_RUN) ? quotient : '0;
         rsp_duty_ff   <= duty_ff;
         rsp_freq_ff   <= freq_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_sel      = rsp_motor_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_prescale_code  = rsp_pre_ff;
   assign rsp_period_compare = rsp_per_ff;
   assign rsp_duty_compare   = rsp_duty_ff;
   assign rsp_tone_freq      = rsp_freq_ff;

endmodule

@@ verif/tb_serial_tone_command_to_timer_setup.sv @@
// Self-checking testbench for the serial tone command decoder and timer setup block.
`timescale 1ns / 100ps

module tb_serial_tone_command_to_timer_setup;
   import stc_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 30;
   localparam int BUSY_PCT      = 32;
   localparam int PHASE_BYTES   = 360;

   localparam logic [FREQ_W-1:0] FREQ_EDGES [12] = '{
      13'd0, 13'd1, 13'd47, 13'd48, 13'd49, 13'd188,
      13'd189, 13'd750, 13'd751, 13'd2000, 13'd2001, 13'd8191
   };
   localparam logic [VELO_W-1:0] VELO_EDGES [5] = '{7'd0, 7'd29, 7'd30, 7'd31, 7'd127};

   // opening bytes with ids at 4 and 5: stray data, stop, each band, clamps,
   // out of range at both ends, address cutting a frame, unknown address
   localparam logic [7:0] OPENING [29] = '{
      8'h12,
      8'h85, 8'h00, 8'h00, 8'h7F,
      8'h84, 8'h00, 8'h62, 8'h00,
      8'h85, 8'h0B, 8'h5D, 8'h1E,
      8'h84, 8'h1F, 8'h20, 8'h1F,
      8'h84, 8'h7F, 8'h7F, 8'h55,
      8'h84, 8'h03, 8'h85, 8'h00, 8'h60, 8'h01,
      8'hFF, 8'h01
   };

   typedef struct {
      logic              motor;
      status_type        status;
      prescale_type      prescale;
      logic [QUO_W-1:0]  period;
      logic [DUTY_W-1:0] duty;
      logic [FREQ_W-1:0] freq;
   } timer_setup_type;

   class timer_setup_tracker;
      logic [ID_W-1:0]   id_a;
      logic [ID_W-1:0]   id_b;
      bit                capture;
      int                count;
      bit                target;
      logic [VELO_W-1:0] held [2];
      timer_setup_type   due_setups [$];
      int                errors;
      int                consumed;
      int                words_checked;
      int                runs;
      int                stops;
      int                ranges;

      function new();
         id_a = MOTOR_A_ID_RST;
         id_b = MOTOR_B_ID_RST;
      endfunction

      function void write_id(reg_index_type idx, logic [ID_W-1:0] value);
         case (idx)
            REG_MOTOR_A_ID: id_a = value;
            REG_MOTOR_B_ID: id_b = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_setups.size();
      endfunction

      function void take_byte(logic [7:0] b);
         logic [13:0]       raw;
         logic [FREQ_W-1:0] f;
         int unsigned       vel;
         timer_setup_type   w;
         if (b[7]) begin
            if (b[6:0] == id_a) begin
               capture = 1'b1;
               target  = 1'b0;
            end else if (b[6:0] == id_b) begin
               capture = 1'b1;
               target  = 1'b1;
            end else begin
               capture = 1'b0;
            end
            count = 0;
            consumed++;
            return;
         end
         if (!capture)
            return;
         consumed++;
         if (count < FRAME_BYTES - 1) begin
            held[count] = b[6:0];
            count++;
            return;
         end
         capture = 1'b0;
         count   = 0;
         raw = {held[0], held[1]};
         f   = raw[13:1];
         vel = 2 * b[6:0];
         if (vel > VELO_MAX)
            vel = VELO_MAX;
         w.motor    = target;
         w.status   = STAT_RANGE;
         w.prescale = PRE_DIV64;
         w.period   = '0;
         w.duty     = '0;
         w.freq     = f;
         if (f == 0) begin
            w.status = STAT_STOP;
         end else if (f > F_MIN && f <= F_LO_TOP) begin
            w.status   = STAT_RUN;
            w.prescale = PRE_DIV1024;
            w.period   = QUO_W'(K_BAND_LO / f);
         end else if (f > F_LO_TOP && f <= F_MID_TOP) begin
            w.status   = STAT_RUN;
            w.prescale = PRE_DIV256;
            w.period   = QUO_W'(K_BAND_MID / f);
         end else if (f > F_MID_TOP && f <= F_MAX) begin
            w.status   = STAT_RUN;
            w.prescale = PRE_DIV64;
            w.period   = QUO_W'(K_BAND_HI / f);
         end
         if (w.status == STAT_RUN) begin
            w.duty = DUTY_W'((DUTY_BASE - vel) * 4);
            runs++;
         end else if (w.status == STAT_STOP) begin
            stops++;
         end else begin
            ranges++;
         end
         due_setups.push_back(w);
      endfunction

      function void compare_field(string what, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      function void check_word(timer_setup_type got);
         timer_setup_type want;
         if (due_setups.size() == 0) begin
            errors++;
            $display("%0t: word with nothing expected, got freq %0d status %0d",
                     $time, got.freq, got.status);
            return;
         end
         want = due_setups.pop_front();
         words_checked++;
         compare_field("motor_sel", 16'(want.motor), 16'(got.motor));
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("prescale_code", 16'(want.prescale), 16'(got.prescale));
         compare_field("period_compare", 16'(want.period), 16'(got.period));
         compare_field("duty_compare", 16'(want.duty), 16'(got.duty));
         compare_field("tone_freq", 16'(want.freq), 16'(got.freq));
      endfunction
   endclass

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic              rsp_motor_sel;
   logic [1:0]        rsp_status;
   logic [1:0]        rsp_prescale_code;
   logic [QUO_W-1:0]  rsp_period_compare;
   logic [DUTY_W-1:0] rsp_duty_compare;
   logic [FREQ_W-1:0] rsp_tone_freq;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index   = REG_MOTOR_A_ID;
   logic [ID_W-1:0]   csr_wdata   = '0;

   timer_setup_tracker sb = new();
   int                 busy_pct = BUSY_PCT;
   int                 quiet_cycles = 0;
   logic [ID_W-1:0]    id_a = MOTOR_A_ID_RST;
   logic [ID_W-1:0]    id_b = MOTOR_B_ID_RST;

   serial_tone_command_to_timer_setup DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motor_sel      (rsp_motor_sel),
      .rsp_status         (rsp_status),
      .rsp_prescale_code  (rsp_prescale_code),
      .rsp_period_compare (rsp_period_compare),
      .rsp_duty_compare   (rsp_duty_compare),
      .rsp_tone_freq      (rsp_tone_freq),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.take_byte(req_rx_byte);
      if (!reset && csr_valid && csr_ready)
         sb.write_id(reg_index_type'(csr_index), csr_wdata);
   end

   // result side: check on the sampled handshake, then pick the next stall
   always @(posedge clock) begin
      timer_setup_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.motor    = rsp_motor_sel;
         got.status   = status_type'(rsp_status);
         got.prescale = prescale_type'(rsp_prescale_code);
         got.period   = rsp_period_compare;
         got.duty     = rsp_duty_compare;
         got.freq     = rsp_tone_freq;
         sb.check_word(got);
      end
      rsp_ready <= ($urandom_range(99) >= busy_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("tb_serial_tone_command_to_timer_setup: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < busy_pct) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(19) == 0) ? $urandom_range(24, 4) : 1) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // ids change only with the block idle: all words back, then a settling pause
   task automatic set_ids(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_MOTOR_A_ID;
      csr_wdata <= a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_MOTOR_B_ID;
      csr_wdata <= b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      id_a = a;
      id_b = b;
   endtask

   task automatic random_traffic(input int amount);
      int                goal;
      int unsigned       roll;
      int unsigned       n;
      logic [FREQ_W-1:0] f;
      logic [13:0]       raw;
      logic [VELO_W-1:0] part [3];
      goal = sb.consumed + amount;
      while (sb.consumed < goal) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            case ($urandom_range(9))
               0, 1, 2:    f = FREQ_EDGES[$urandom_range(11)];
               3, 4, 5, 6: f = FREQ_W'($urandom_range(2000, 49));
               default:    f = FREQ_W'($urandom());
            endcase
            raw     = {f, 1'($urandom())};
            part[0] = raw[13:7];
            part[1] = raw[6:0];
            part[2] = ($urandom_range(3) == 0) ? VELO_EDGES[$urandom_range(4)]
                                               : VELO_W'($urandom());
            // most frames run to completion, the rest get cut short
            n = (roll < 75) ? 3 : $urandom_range(2);
            send_byte({1'b1, ($urandom_range(1) != 0) ? id_a : id_b});
            for (int i = 0; i < n; i++)
               send_byte({1'b0, part[i]});
         end else if (roll < 93) begin
            send_byte({1'b1, 7'($urandom())});
            n = $urandom_range(2);
            for (int i = 0; i < n; i++)
               send_byte({1'b0, 7'($urandom())});
         end else begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
               send_byte({1'b0, 7'($urandom())});
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i])
         send_byte(OPENING[i]);
      random_traffic(PHASE_BYTES);

      set_ids('0, '1);
      random_traffic(PHASE_BYTES);

      // equal ids select motor A; this stretch runs with no stalls on either side
      set_ids(7'd42, 7'd42);
      busy_pct = 0;
      random_traffic(PHASE_BYTES - 60);
      busy_pct = BUSY_PCT;

      set_ids(7'($urandom()), 7'($urandom()));
      random_traffic(PHASE_BYTES);

      set_ids('1, '0);
      random_traffic(PHASE_BYTES);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d timer words never arrived", $time, sb.pending());
      end

      $display("Covered %0d bytes over five id settings; %0d timer words checked",
               sb.consumed, sb.words_checked);
      $display("Words by outcome: %0d running, %0d stopped, %0d out of range, %0d mismatches",
               sb.runs, sb.stops, sb.ranges, sb.errors);
      if (sb.errors == 0)
         $display("tb_serial_tone_command_to_timer_setup: clean");
      else
         $display("tb_serial_tone_command_to_timer_setup: errors");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/stc_pkg.sv
rtl/stc_frame.sv
rtl/stc_div.sv
rtl/serial_tone_command_to_timer_setup.sv
verif/tb_serial_tone_command_to_timer_setup.sv
